[rtl/dtes_pkg.sv]
// Shared types, constants and calendar tables for the date-to-epoch converter.
// No dependencies; imported by every module of the block but the checker.
package dtes_pkg;

  localparam logic [13:0]        EpochYear       = 14'd1970;
  localparam logic [23:0]        EpochDayShift   = 24'd719468;
  localparam logic [16:0]        SecPerDay       = 17'd86400;
  localparam logic signed [16:0] ZoneOffsetReset = 17'sd28800;
  localparam logic [12:0]        Recip100        = 13'd5243;

  // Classified item handed from the front to the back through the queue
  typedef struct packed {
    logic        ok;
    logic [13:0] year_adj;
    logic [8:0]  doy;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } dtes_item_t;

  // Floor of v / 100 by reciprocal multiply; exact for every 14-bit v
  function automatic logic [7:0] div100(input logic [13:0] v);
    logic [26:0] p;
    p = {13'd0, v} * {14'd0, Recip100};
    return p[26:19];
  endfunction

  // Length of a month in a common year; zero for codes that are no month
  function automatic logic [4:0] month_len(input logic [6:0] m);
    logic [4:0] len;
    case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
      7'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days from 1 March to the first of the month, years starting in March
  function automatic logic [8:0] march_offset(input logic [6:0] m);
    logic [8:0] off;
    case (m)
      7'd3:    off = 9'd0;
      7'd4:    off = 9'd31;
      7'd5:    off = 9'd61;
      7'd6:    off = 9'd92;
      7'd7:    off = 9'd122;
      7'd8:    off = 9'd153;
      7'd9:    off = 9'd184;
      7'd10:   off = 9'd214;
      7'd11:   off = 9'd245;
      7'd12:   off = 9'd275;
      7'd1:    off = 9'd306;
      7'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

[rtl/dtes_front.sv]
// Front end: range checks on the raw date and time fields, leap-year rule,
// and reduction of the date to a March-based year and day of year. Uses dtes_pkg.
module dtes_front (
  input  logic [13:0]         year_i,
  input  logic [6:0]          month_i,
  input  logic [6:0]          day_i,
  input  logic [6:0]          hour_i,
  input  logic [6:0]          minute_i,
  input  logic [6:0]          second_i,
  output dtes_pkg::dtes_item_t item_o
);
  import dtes_pkg::*;

  logic [7:0]  cent;
  logic [14:0] cent_x100;
  logic        cent_year;
  logic        leap;
  logic [4:0]  mlen;
  logic        date_ok;
  logic        time_ok;
  logic        feb;

  assign feb       = (month_i == 7'd2);
  assign cent      = div100(year_i);
  assign cent_x100 = {7'd0, cent} * 15'd100;
  assign cent_year = ({1'b0, year_i} == cent_x100);
  // divisible by 4, and not by 100 unless also by 400
  assign leap      = (year_i[1:0] == 2'b00) && (!cent_year || (cent[1:0] == 2'b00));
  assign mlen      = month_len(month_i) + {4'd0, feb && leap};

  assign date_ok = (year_i >= EpochYear) && (month_i >= 7'd1) && (month_i <= 7'd12) &&
                   (day_i != 7'd0) && (day_i <= {2'b00, mlen});
  assign time_ok = (hour_i <= 7'd23) && (minute_i <= 7'd59) && (second_i <= 7'd59);

  always_comb begin
    item_o.ok       = date_ok && time_ok;
    // January and February count with the year before
    item_o.year_adj = year_i - {13'd0, month_i <= 7'd2};
    item_o.doy      = march_offset(month_i) + {4'd0, day_i[4:0]} - 9'd1;
    item_o.hour     = hour_i[4:0];
    item_o.minute   = minute_i[5:0];
    item_o.second   = second_i[5:0];
  end

endmodule

[rtl/dtes_fifo.sv]
// Short queue of classified items between the front and the back end.
// Uses dtes_pkg for the item type.
module dtes_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  dtes_pkg::dtes_item_t push_item_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output dtes_pkg::dtes_item_t pop_item_o
);
  import dtes_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dtes_item_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[rtl/dtes_back.sv]
// Back end: day count, scaling to seconds, zone offset and result register,
// as a four-stage pipeline that stalls as one. Uses dtes_pkg.
module dtes_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic signed [16:0]   zone_offset_i,
  input  logic                 item_valid_i,
  output logic                 item_ready_o,
  input  dtes_pkg::dtes_item_t item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 valid_res_o,
  output logic [37:0]          epoch_seconds_o
);
  import dtes_pkg::*;

  logic adv;

  // stage 1: year terms and time of day
  logic        v1_q;
  logic        ok1_q;
  logic [22:0] y365_q, y365_d;
  logic [11:0] yq4_q;
  logic [7:0]  cent_q;
  logic [8:0]  doy1_q;
  logic [16:0] tod1_q, tod1_d;

  // stage 2: day count since the epoch
  logic        v2_q;
  logic        ok2_q;
  logic [23:0] days_sum;
  logic [22:0] days_q;
  logic [16:0] tod2_q;

  // stage 3: days scaled to seconds, time of day less zone offset
  logic        v3_q;
  logic        ok3_q;
  logic [39:0] prod_q, prod_d;
  logic [18:0] tzt_q, tzt_d;

  // result register
  logic        out_vld_q;
  logic        res_ok_q, res_ok_d;
  logic [37:0] res_sec_q, res_sec_d;
  logic [41:0] secs;

  // advance every stage unless a result is held back
  assign adv          = !out_vld_q || out_ready_i;
  assign item_ready_o = adv;

  assign y365_d = {9'd0, item_i.year_adj} * 23'd365;
  assign tod1_d = {12'd0, item_i.hour} * 17'd3600 + {11'd0, item_i.minute} * 17'd60 +
                  {11'd0, item_i.second};

  assign days_sum = {1'b0, y365_q} + {12'd0, yq4_q} + {18'd0, cent_q[7:2]} +
                    {15'd0, doy1_q} - {16'd0, cent_q} - EpochDayShift;

  assign prod_d = {17'd0, days_q} * {23'd0, SecPerDay};
  assign tzt_d  = {2'b00, tod2_q} - {{2{zone_offset_i[16]}}, zone_offset_i};

  assign secs = {2'b00, prod_q} + {{23{tzt_q[18]}}, tzt_q};

  always_comb begin
    // keep only results above zero that fit the output width
    res_ok_d  = ok3_q && (secs[41:38] == 4'd0) && (secs != '0);
    res_sec_d = res_ok_d ? secs[37:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= item_valid_i;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      out_vld_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok1_q     <= item_i.ok;
      y365_q    <= y365_d;
      yq4_q     <= item_i.year_adj[13:2];
      cent_q    <= div100(item_i.year_adj);
      doy1_q    <= item_i.doy;
      tod1_q    <= tod1_d;
      ok2_q     <= ok1_q;
      days_q    <= days_sum[22:0];
      tod2_q    <= tod1_q;
      ok3_q     <= ok2_q;
      prod_q    <= prod_d;
      tzt_q     <= tzt_d;
      res_ok_q  <= res_ok_d;
      res_sec_q <= res_sec_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign valid_res_o     = res_ok_q;
  assign epoch_seconds_o = res_sec_q;

endmodule

[rtl/civil_datetime_to_epoch_seconds_core.sv]
// Calendar date and time to Unix epoch seconds. A taken input beat passes the
// queue read, the three back-end stages and the result register before its result
// is shown. Throughput: one beat per cycle while the output is not stalled.
// Reset clears the queue and pipeline valid state; the zone offset returns to 28800 s.
// Depends on dtes_pkg, dtes_front, dtes_fifo and dtes_back.
module civil_datetime_to_epoch_seconds_core #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic signed [16:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [13:0]        year_i,
  input  logic [6:0]         month_i,
  input  logic [6:0]         day_i,
  input  logic [6:0]         hour_i,
  input  logic [6:0]         minute_i,
  input  logic [6:0]         second_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               valid_res_o,
  output logic [37:0]        epoch_seconds_o
);
  import dtes_pkg::*;

  logic signed [16:0] zone_off_q;
  dtes_item_t         front_item;
  dtes_item_t         queue_item;
  logic               queue_valid;
  logic               queue_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_off_q <= ZoneOffsetReset;
    end else if (cfg_we_i) begin
      zone_off_q <= cfg_wdata_i;
    end
  end

  dtes_front u_front (
    .year_i   (year_i),
    .month_i  (month_i),
    .day_i    (day_i),
    .hour_i   (hour_i),
    .minute_i (minute_i),
    .second_i (second_i),
    .item_o   (front_item)
  );

  dtes_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_item_o   (queue_item)
  );

  dtes_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .zone_offset_i   (zone_off_q),
    .item_valid_i    (queue_valid),
    .item_ready_o    (queue_ready),
    .item_i          (queue_item),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .valid_res_o     (valid_res_o),
    .epoch_seconds_o (epoch_seconds_o)
  );

endmodule

[rtl/dtes_checker.sv]
// Port-level checks on the converter's result channel, bound to the top level.
// Depends only on the ports of civil_datetime_to_epoch_seconds_core.
module dtes_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        valid_res_o,
  input logic [37:0] epoch_seconds_o
);

  // hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(valid_res_o) &&
                                    $stable(epoch_seconds_o))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> epoch_seconds_o == 38'd0)
    else $error("invalid result carries nonzero seconds");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |-> epoch_seconds_o != 38'd0)
    else $error("valid result at or before the epoch");

  // the valid flag is only defined once reset has been seen at a clock edge
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result shown during reset");

endmodule

bind civil_datetime_to_epoch_seconds_core dtes_checker u_dtes_checker (.*);
